/* hdl/terminal_line_editor_with_history_core_macros.svh */
// Assertion helpers for the line editor datapath RTL.
`ifndef TERMINAL_LINE_EDITOR_WITH_HISTORY_CORE_MACROS_SVH
`define TERMINAL_LINE_EDITOR_WITH_HISTORY_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define TLE_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/tle_pkg.sv */
`default_nettype none
package tle_pkg;

  // Received byte codes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BRACK = 8'h5B;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_MARK = 2'd2;

  // Line end modes
  localparam logic [1:0] MODE_CR   = 2'd0;
  localparam logic [1:0] MODE_LF   = 2'd1;
  localparam logic [1:0] MODE_CRLF = 2'd2;

  // Escape phases
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_CSI   = 2'd2;
  localparam logic [1:0] PH_THREE = 2'd3;

  // Register map
  localparam logic REG_END_MODE = 1'b0;
  localparam logic REG_BS_CODE  = 1'b1;

  localparam int LEN_OUT_W = 4;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR_CR, OP_SET_CR, OP_BS_PREP, OP_DEL_PREP,
    OP_RM_RD, OP_RM_WR, OP_LEN_DEC, OP_TAIL_ZERO, OP_RD_IDX, OP_IDX_INC,
    OP_IDX_DEC, OP_INS_PREP, OP_SH_RD, OP_SH_WR, OP_INS_PUT, OP_CUR_INC_REP,
    OP_REP_DEC, OP_CUR_DEC, OP_CUR_INC, OP_RD_CUR, OP_RC_PREP, OP_BROWSE,
    OP_CP_PREP, OP_CP_RD, OP_CP_WR, OP_RC_END, OP_FIN_END
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RM_RD, S_RM_WR, S_LEN_DEC, S_E_SP0, S_E_BS0,
    S_TL_RD, S_TL_EM, S_E_SP1, S_BS_REP, S_INS_SH_RD, S_INS_SH_WR,
    S_INS_PUT, S_INS_FIX, S_LEFT, S_RD_C, S_RIGHT, S_RC_BS, S_RC_BR,
    S_CP_PREP, S_CP_RD, S_CP_WR, S_RC_END, S_SP_REP, S_FIN, S_E_MARK,
    S_FIN_END, S_DONE
  } state_e;

  typedef enum logic [2:0] {P_BS, P_DEL, P_INS, P_RC, P_FIN} path_e;

  typedef enum logic [3:0] {
    ACT_NOP, ACT_CR_DROP, ACT_CR_FIN, ACT_SET_CR, ACT_FIN, ACT_ESC, ACT_CSI,
    ACT_THREE, ACT_BS, ACT_DEL, ACT_INS, ACT_RECALL, ACT_LEFT, ACT_RIGHT
  } act_e;

  typedef struct packed {
    dp_op_e     op;
    logic       phase_we;
    logic [1:0] phase_val;
    logic       emit;
    logic [1:0] emit_kind;
    logic [7:0] emit_ch;
    logic       emit_rd;
    logic       flush;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] rx_char;
    logic [1:0] mode;
    logic [7:0] bs_code;
    logic [1:0] phase;
    logic       cr_pend;
    logic       cur_zero;
    logic       cur_lt_len;
    logic       len_full;
    logic       idx_lt_len;
    logic       rm_more;
    logic       sh_more;
    logic       rep_zero;
    logic       idx_zero;
    logic       can_emit;
    logic       flush_ok;
    logic       hold_v;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hdl/tle_dp.sv */
`default_nettype none
`include "terminal_line_editor_with_history_core_macros.svh"
module tle_dp #(
  parameter int LINE_SIZE     = 16,
  parameter int HISTORY_SLOTS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           rx_char_i,
  input  wire tle_pkg::dp_cmd_t     cmd_i,
  output tle_pkg::dp_stat_t         stat_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                out_char_o,
  output logic [tle_pkg::LEN_OUT_W-1:0] line_length_o,
  output logic                      last_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int PW = $clog2(LINE_SIZE);
  localparam int SW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int AW = SW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [PW-1:0] LEN_MAX  = PW'(LINE_SIZE - 1);
  localparam logic [SW-1:0] SLOT_MAX = SW'(HISTORY_SLOTS - 1);
  localparam int LEN_OUT_W_L = tle_pkg::LEN_OUT_W;

  logic [7:0]    char_q, char_d;
  logic [1:0]    end_mode_q;
  logic [7:0]    bs_code_q;
  logic [1:0]    phase_q, phase_d;
  logic          cr_q, cr_d;
  logic [PW-1:0] cursor_q, cursor_d, len_q, len_d, idx_q, idx_d;
  logic [PW-1:0] rep_q, rep_d, old_q, old_d;
  logic [SW-1:0] work_q, work_d, highest_q, highest_d, browse_q, browse_d;
  logic [PW-1:0] slen_q [HISTORY_SLOTS];
  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rd_q;

  logic          hold_v_q, out_v_q;
  logic [1:0]    hold_kind_q, out_kind_q;
  logic [7:0]    hold_char_q, out_char_q;
  logic [LEN_OUT_W_L-1:0] hold_len_q, out_len_q;
  logic          out_last_q;

  logic          cfg_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;
  logic          mem_we, mem_re;
  logic [SW:0]   w_inc;
  logic [SW-1:0] fin_hi, fin_work;
  logic          can_emit, flush_ok;
  logic [7:0]    emit_char;
  logic [LEN_OUT_W_L-1:0] emit_len;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    if (paddr[2] == tle_pkg::REG_BS_CODE) begin
      prdata = {24'd0, bs_code_q};
    end else begin
      prdata = {30'd0, end_mode_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_mode_q <= tle_pkg::MODE_CR;
      bs_code_q  <= tle_pkg::CH_BS;
    end else if (cfg_we) begin
      if (paddr[2] == tle_pkg::REG_BS_CODE) begin
        bs_code_q <= pwdata[7:0];
      end else begin
        end_mode_q <= pwdata[1:0];
      end
    end
  end

  // Slot bookkeeping at line end
  assign w_inc  = {1'b0, work_q} + 1'b1;
  assign fin_hi = (len_q != '0 && highest_q < SLOT_MAX) ? highest_q + 1'b1 : highest_q;
  always_comb begin
    if (len_q == '0) begin
      fin_work = work_q;
    end else if (w_inc > {1'b0, fin_hi}) begin
      fin_work = '0;
    end else begin
      fin_work = w_inc[SW-1:0];
    end
  end

  // Editing state next values
  always_comb begin
    char_d    = char_q;
    phase_d   = phase_q;
    cr_d      = cr_q;
    cursor_d  = cursor_q;
    len_d     = len_q;
    idx_d     = idx_q;
    rep_d     = rep_q;
    old_d     = old_q;
    work_d    = work_q;
    highest_d = highest_q;
    browse_d  = browse_q;
    if (cmd_i.phase_we) begin
      phase_d = cmd_i.phase_val;
    end
    case (cmd_i.op)
      tle_pkg::OP_LATCH:    char_d = rx_char_i;
      tle_pkg::OP_CLR_CR:   cr_d = 1'b0;
      tle_pkg::OP_SET_CR:   cr_d = 1'b1;
      tle_pkg::OP_BS_PREP: begin
        cursor_d = cursor_q - 1'b1;
        rep_d    = len_q - cursor_q + 1'b1;
        idx_d    = cursor_q - 1'b1;
      end
      tle_pkg::OP_DEL_PREP: begin
        rep_d = len_q - cursor_q;
        idx_d = cursor_q;
      end
      tle_pkg::OP_RM_WR:    idx_d = idx_q + 1'b1;
      tle_pkg::OP_LEN_DEC: begin
        len_d = len_q - 1'b1;
        idx_d = cursor_q;
      end
      tle_pkg::OP_TAIL_ZERO: idx_d = '0;
      tle_pkg::OP_IDX_INC:  idx_d = idx_q + 1'b1;
      tle_pkg::OP_IDX_DEC:  idx_d = idx_q - 1'b1;
      tle_pkg::OP_INS_PREP: idx_d = len_q;
      tle_pkg::OP_SH_WR:    idx_d = idx_q - 1'b1;
      tle_pkg::OP_INS_PUT: begin
        len_d = len_q + 1'b1;
        idx_d = cursor_q;
      end
      tle_pkg::OP_CUR_INC_REP: begin
        cursor_d = cursor_q + 1'b1;
        rep_d    = len_q - cursor_q - 1'b1;
      end
      tle_pkg::OP_REP_DEC:  rep_d = rep_q - 1'b1;
      tle_pkg::OP_CUR_DEC:  cursor_d = cursor_q - 1'b1;
      tle_pkg::OP_CUR_INC:  cursor_d = cursor_q + 1'b1;
      tle_pkg::OP_RC_PREP: begin
        rep_d = cursor_q;
        old_d = len_q;
      end
      tle_pkg::OP_BROWSE: begin
        if (char_q == tle_pkg::CH_UP) begin
          browse_d = (browse_q == '0) ? highest_q : browse_q - 1'b1;
        end else begin
          browse_d = (browse_q >= highest_q) ? '0 : browse_q + 1'b1;
        end
      end
      tle_pkg::OP_CP_PREP: begin
        idx_d = '0;
        if (browse_q != work_q) begin
          len_d = (slen_q[browse_q] > LEN_MAX) ? LEN_MAX : slen_q[browse_q];
        end else begin
          len_d = '0;
        end
      end
      tle_pkg::OP_CP_WR:    idx_d = idx_q + 1'b1;
      tle_pkg::OP_RC_END: begin
        cursor_d = len_q;
        if (old_q > len_q) begin
          rep_d = old_q - len_q;
          idx_d = old_q - len_q;
        end else begin
          rep_d = '0;
          idx_d = '0;
        end
      end
      tle_pkg::OP_FIN_END: begin
        highest_d = fin_hi;
        work_d    = fin_work;
        browse_d  = fin_work;
        len_d     = '0;
        cursor_d  = '0;
        phase_d   = tle_pkg::PH_NONE;
        cr_d      = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tle_pkg::PH_NONE;
      cr_q      <= 1'b0;
      cursor_q  <= '0;
      len_q     <= '0;
      work_q    <= '0;
      highest_q <= '0;
      browse_q  <= '0;
      for (int i = 0; i < HISTORY_SLOTS; i++) begin
        slen_q[i] <= '0;
      end
    end else begin
      phase_q   <= phase_d;
      cr_q      <= cr_d;
      cursor_q  <= cursor_d;
      len_q     <= len_d;
      work_q    <= work_d;
      highest_q <= highest_d;
      browse_q  <= browse_d;
      if (cmd_i.op == tle_pkg::OP_FIN_END) begin
        // the next working slot always starts empty
        if (fin_work != work_q) begin
          slen_q[work_q] <= len_q;
        end
        slen_q[fin_work] <= '0;
      end
    end
  end

  // Working counters and the latched byte
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    idx_q  <= idx_d;
    rep_q  <= rep_d;
    old_q  <= old_d;
  end

  // Line store address and data
  always_comb begin
    mem_addr = {work_q, idx_q};
    mem_wd   = rd_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    case (cmd_i.op)
      tle_pkg::OP_RM_RD: begin
        mem_addr = {work_q, idx_q + 1'b1};
        mem_re   = 1'b1;
      end
      tle_pkg::OP_SH_RD: begin
        mem_addr = {work_q, idx_q - 1'b1};
        mem_re   = 1'b1;
      end
      tle_pkg::OP_RD_IDX: mem_re = 1'b1;
      tle_pkg::OP_RD_CUR: begin
        mem_addr = {work_q, cursor_q};
        mem_re   = 1'b1;
      end
      tle_pkg::OP_CP_RD: begin
        mem_addr = {browse_q, idx_q};
        mem_re   = 1'b1;
      end
      tle_pkg::OP_RM_WR, tle_pkg::OP_SH_WR, tle_pkg::OP_CP_WR: mem_we = 1'b1;
      tle_pkg::OP_INS_PUT: begin
        mem_addr = {work_q, cursor_q};
        mem_wd   = char_q;
        mem_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Result staging: one held result, one output register
  assign can_emit  = !hold_v_q || !out_v_q || out_ready_i;
  assign flush_ok  = !out_v_q || out_ready_i;
  assign emit_char = cmd_i.emit_rd ? rd_q : cmd_i.emit_ch;
  assign emit_len  = (cmd_i.emit_kind == tle_pkg::KIND_MARK) ? LEN_OUT_W_L'(len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
      // a new load wins over the handover of the old one
      if ((cmd_i.emit && hold_v_q) || cmd_i.flush) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hold_kind_q <= cmd_i.emit_kind;
      hold_char_q <= emit_char;
      hold_len_q  <= emit_len;
    end
    if ((cmd_i.emit && hold_v_q) || cmd_i.flush) begin
      out_kind_q <= hold_kind_q;
      out_char_q <= hold_char_q;
      out_len_q  <= hold_len_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_kind_q;
  assign out_char_o    = out_char_q;
  assign line_length_o = out_len_q;
  assign last_o        = out_last_q;

  // Status toward the controller
  always_comb begin
    stat_o.rx_char    = char_q;
    stat_o.mode       = (end_mode_q == 2'd3) ? tle_pkg::MODE_CRLF : end_mode_q;
    stat_o.bs_code    = bs_code_q;
    stat_o.phase      = phase_q;
    stat_o.cr_pend    = cr_q;
    stat_o.cur_zero   = (cursor_q == '0);
    stat_o.cur_lt_len = (cursor_q < len_q);
    stat_o.len_full   = (len_q >= LEN_MAX);
    stat_o.idx_lt_len = (idx_q < len_q);
    stat_o.rm_more    = (({1'b0, idx_q} + 1'b1) < {1'b0, len_q});
    stat_o.sh_more    = (idx_q > cursor_q);
    stat_o.rep_zero   = (rep_q == '0);
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.can_emit   = can_emit;
    stat_o.flush_ok   = flush_ok;
    stat_o.hold_v     = hold_v_q;
  end

  `TLE_ASSERT_NEXT(a_cursor_in_line, cmd_i.op == tle_pkg::OP_LATCH, cursor_q <= len_q, "cursor past line end")
  `TLE_ASSERT(a_len_bound, len_q <= LEN_MAX, "line longer than its slot")
  `TLE_ASSERT(a_slot_order, work_q <= highest_q && highest_q <= SLOT_MAX, "slot index out of range")
  `TLE_ASSERT_NEXT(a_flush_last, cmd_i.flush, out_v_q && out_last_q, "final result not marked")

endmodule
`default_nettype wire

/* hdl/tle_ctrl.sv */
`default_nettype none
module tle_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tle_pkg::dp_stat_t stat_i,
  output tle_pkg::dp_cmd_t       cmd_o
);

  tle_pkg::state_e state_q, state_d;
  tle_pkg::path_e  path_q, path_d;
  tle_pkg::act_e   act;
  logic [7:0]      c;

  assign c = stat_i.rx_char;

  // Classify the latched byte
  always_comb begin
    act = tle_pkg::ACT_NOP;
    if (stat_i.mode == tle_pkg::MODE_CRLF && stat_i.cr_pend) begin
      act = (c == tle_pkg::CH_LF) ? tle_pkg::ACT_CR_FIN : tle_pkg::ACT_CR_DROP;
    end else if (stat_i.mode != tle_pkg::MODE_LF && c == tle_pkg::CH_CR) begin
      act = (stat_i.mode == tle_pkg::MODE_CR) ? tle_pkg::ACT_FIN : tle_pkg::ACT_SET_CR;
    end else if (stat_i.mode == tle_pkg::MODE_LF && c == tle_pkg::CH_LF) begin
      act = tle_pkg::ACT_FIN;
    end else begin
      case (stat_i.phase)
        tle_pkg::PH_NONE: begin
          if (c == tle_pkg::CH_ESC) begin
            act = tle_pkg::ACT_ESC;
          end else if (c == stat_i.bs_code) begin
            if (!stat_i.cur_zero) act = tle_pkg::ACT_BS;
          end else if (c == tle_pkg::CH_DEL) begin
            if (stat_i.cur_lt_len) act = tle_pkg::ACT_DEL;
          end else if (c inside {[tle_pkg::CH_SPACE:tle_pkg::CH_TILDE]}) begin
            if (!stat_i.len_full) act = tle_pkg::ACT_INS;
          end
        end
        tle_pkg::PH_ESC: begin
          if (c == tle_pkg::CH_BRACK) act = tle_pkg::ACT_CSI;
        end
        tle_pkg::PH_CSI: begin
          if (c == tle_pkg::CH_UP || c == tle_pkg::CH_DOWN) begin
            act = tle_pkg::ACT_RECALL;
          end else if (c == tle_pkg::CH_LEFT) begin
            if (!stat_i.cur_zero) act = tle_pkg::ACT_LEFT;
          end else if (c == tle_pkg::CH_RIGHT) begin
            if (stat_i.cur_lt_len) act = tle_pkg::ACT_RIGHT;
          end else if (c == tle_pkg::CH_THREE) begin
            act = tle_pkg::ACT_THREE;
          end
        end
        default: begin
          if (c == tle_pkg::CH_TILDE && stat_i.cur_lt_len) act = tle_pkg::ACT_DEL;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    path_d  = path_q;
    case (state_q)
      tle_pkg::S_IDLE: if (in_valid_i) state_d = tle_pkg::S_DECODE;
      tle_pkg::S_DECODE: begin
        case (act)
          tle_pkg::ACT_FIN, tle_pkg::ACT_CR_FIN: begin
            state_d = tle_pkg::S_FIN;
            path_d  = tle_pkg::P_FIN;
          end
          tle_pkg::ACT_BS: begin
            state_d = tle_pkg::S_RM_RD;
            path_d  = tle_pkg::P_BS;
          end
          tle_pkg::ACT_DEL: begin
            state_d = tle_pkg::S_RM_RD;
            path_d  = tle_pkg::P_DEL;
          end
          tle_pkg::ACT_INS: begin
            state_d = tle_pkg::S_INS_SH_RD;
            path_d  = tle_pkg::P_INS;
          end
          tle_pkg::ACT_RECALL: begin
            state_d = tle_pkg::S_RC_BS;
            path_d  = tle_pkg::P_RC;
          end
          tle_pkg::ACT_LEFT:  state_d = tle_pkg::S_LEFT;
          tle_pkg::ACT_RIGHT: state_d = tle_pkg::S_RD_C;
          default:            state_d = tle_pkg::S_DONE;
        endcase
      end
      tle_pkg::S_RM_RD: state_d = stat_i.rm_more ? tle_pkg::S_RM_WR : tle_pkg::S_LEN_DEC;
      tle_pkg::S_RM_WR: state_d = tle_pkg::S_RM_RD;
      tle_pkg::S_LEN_DEC: begin
        state_d = (path_q == tle_pkg::P_DEL) ? tle_pkg::S_E_SP0 : tle_pkg::S_E_BS0;
      end
      tle_pkg::S_E_SP0: if (stat_i.can_emit) state_d = tle_pkg::S_E_BS0;
      tle_pkg::S_E_BS0: if (stat_i.can_emit) state_d = tle_pkg::S_TL_RD;
      tle_pkg::S_TL_RD: begin
        if (stat_i.idx_lt_len) begin
          state_d = tle_pkg::S_TL_EM;
        end else begin
          case (path_q)
            tle_pkg::P_INS: state_d = tle_pkg::S_INS_FIX;
            tle_pkg::P_RC:  state_d = tle_pkg::S_RC_END;
            tle_pkg::P_FIN: state_d = tle_pkg::S_E_MARK;
            default:        state_d = tle_pkg::S_E_SP1;
          endcase
        end
      end
      tle_pkg::S_TL_EM: if (stat_i.can_emit) state_d = tle_pkg::S_TL_RD;
      tle_pkg::S_E_SP1: if (stat_i.can_emit) state_d = tle_pkg::S_BS_REP;
      tle_pkg::S_BS_REP: if (stat_i.rep_zero) state_d = tle_pkg::S_DONE;
      tle_pkg::S_INS_SH_RD: begin
        state_d = stat_i.sh_more ? tle_pkg::S_INS_SH_WR : tle_pkg::S_INS_PUT;
      end
      tle_pkg::S_INS_SH_WR: state_d = tle_pkg::S_INS_SH_RD;
      tle_pkg::S_INS_PUT:   state_d = tle_pkg::S_TL_RD;
      tle_pkg::S_INS_FIX:   state_d = tle_pkg::S_BS_REP;
      tle_pkg::S_LEFT:  if (stat_i.can_emit) state_d = tle_pkg::S_DONE;
      tle_pkg::S_RD_C:  state_d = tle_pkg::S_RIGHT;
      tle_pkg::S_RIGHT: if (stat_i.can_emit) state_d = tle_pkg::S_DONE;
      tle_pkg::S_RC_BS: if (stat_i.rep_zero) state_d = tle_pkg::S_RC_BR;
      tle_pkg::S_RC_BR:   state_d = tle_pkg::S_CP_PREP;
      tle_pkg::S_CP_PREP: state_d = tle_pkg::S_CP_RD;
      tle_pkg::S_CP_RD: state_d = stat_i.idx_lt_len ? tle_pkg::S_CP_WR : tle_pkg::S_TL_RD;
      tle_pkg::S_CP_WR:  state_d = tle_pkg::S_CP_RD;
      tle_pkg::S_RC_END: state_d = tle_pkg::S_SP_REP;
      tle_pkg::S_SP_REP: if (stat_i.idx_zero) state_d = tle_pkg::S_BS_REP;
      tle_pkg::S_FIN:    if (stat_i.can_emit) state_d = tle_pkg::S_TL_RD;
      tle_pkg::S_E_MARK: if (stat_i.can_emit) state_d = tle_pkg::S_FIN_END;
      tle_pkg::S_FIN_END: state_d = tle_pkg::S_DONE;
      tle_pkg::S_DONE: begin
        if (!stat_i.hold_v || stat_i.flush_ok) state_d = tle_pkg::S_IDLE;
      end
      default: state_d = tle_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = tle_pkg::OP_NONE;
    cmd_o.emit_kind = tle_pkg::KIND_ECHO;
    cmd_o.emit_ch   = tle_pkg::CH_NUL;
    in_ready_o      = 1'b0;
    case (state_q)
      tle_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = tle_pkg::OP_LATCH;
      end
      tle_pkg::S_DECODE: begin
        cmd_o.phase_we = 1'b1;
        case (act)
          tle_pkg::ACT_CR_DROP, tle_pkg::ACT_CR_FIN: begin
            cmd_o.op       = tle_pkg::OP_CLR_CR;
            cmd_o.phase_we = 1'b0;
          end
          tle_pkg::ACT_SET_CR: begin
            cmd_o.op       = tle_pkg::OP_SET_CR;
            cmd_o.phase_we = 1'b0;
          end
          tle_pkg::ACT_FIN:    cmd_o.phase_we = 1'b0;
          tle_pkg::ACT_ESC:    cmd_o.phase_val = tle_pkg::PH_ESC;
          tle_pkg::ACT_CSI:    cmd_o.phase_val = tle_pkg::PH_CSI;
          tle_pkg::ACT_THREE:  cmd_o.phase_val = tle_pkg::PH_THREE;
          tle_pkg::ACT_BS:     cmd_o.op = tle_pkg::OP_BS_PREP;
          tle_pkg::ACT_DEL:    cmd_o.op = tle_pkg::OP_DEL_PREP;
          tle_pkg::ACT_INS:    cmd_o.op = tle_pkg::OP_INS_PREP;
          tle_pkg::ACT_RECALL: cmd_o.op = tle_pkg::OP_RC_PREP;
          default: ;
        endcase
      end
      tle_pkg::S_RM_RD: if (stat_i.rm_more) cmd_o.op = tle_pkg::OP_RM_RD;
      tle_pkg::S_RM_WR:   cmd_o.op = tle_pkg::OP_RM_WR;
      tle_pkg::S_LEN_DEC: cmd_o.op = tle_pkg::OP_LEN_DEC;
      tle_pkg::S_E_SP0, tle_pkg::S_E_SP1: begin
        cmd_o.emit    = stat_i.can_emit;
        cmd_o.emit_ch = tle_pkg::CH_SPACE;
      end
      tle_pkg::S_E_BS0: begin
        cmd_o.emit    = stat_i.can_emit;
        cmd_o.emit_ch = tle_pkg::CH_BS;
      end
      tle_pkg::S_TL_RD: if (stat_i.idx_lt_len) cmd_o.op = tle_pkg::OP_RD_IDX;
      tle_pkg::S_TL_EM: begin
        cmd_o.emit      = stat_i.can_emit;
        cmd_o.emit_rd   = 1'b1;
        cmd_o.emit_kind = (path_q == tle_pkg::P_FIN) ? tle_pkg::KIND_LINE
                                                     : tle_pkg::KIND_ECHO;
        if (stat_i.can_emit) cmd_o.op = tle_pkg::OP_IDX_INC;
      end
      tle_pkg::S_BS_REP, tle_pkg::S_RC_BS: begin
        cmd_o.emit_ch = tle_pkg::CH_BS;
        if (!stat_i.rep_zero && stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = tle_pkg::OP_REP_DEC;
        end
      end
      tle_pkg::S_INS_SH_RD: if (stat_i.sh_more) cmd_o.op = tle_pkg::OP_SH_RD;
      tle_pkg::S_INS_SH_WR: cmd_o.op = tle_pkg::OP_SH_WR;
      tle_pkg::S_INS_PUT:   cmd_o.op = tle_pkg::OP_INS_PUT;
      tle_pkg::S_INS_FIX:   cmd_o.op = tle_pkg::OP_CUR_INC_REP;
      tle_pkg::S_LEFT: begin
        cmd_o.emit_ch = tle_pkg::CH_BS;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = tle_pkg::OP_CUR_DEC;
        end
      end
      tle_pkg::S_RD_C: cmd_o.op = tle_pkg::OP_RD_CUR;
      tle_pkg::S_RIGHT: begin
        cmd_o.emit_rd = 1'b1;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = tle_pkg::OP_CUR_INC;
        end
      end
      tle_pkg::S_RC_BR:   cmd_o.op = tle_pkg::OP_BROWSE;
      tle_pkg::S_CP_PREP: cmd_o.op = tle_pkg::OP_CP_PREP;
      tle_pkg::S_CP_RD: begin
        cmd_o.op = stat_i.idx_lt_len ? tle_pkg::OP_CP_RD : tle_pkg::OP_TAIL_ZERO;
      end
      tle_pkg::S_CP_WR:  cmd_o.op = tle_pkg::OP_CP_WR;
      tle_pkg::S_RC_END: cmd_o.op = tle_pkg::OP_RC_END;
      tle_pkg::S_SP_REP: begin
        cmd_o.emit_ch = tle_pkg::CH_SPACE;
        if (!stat_i.idx_zero && stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = tle_pkg::OP_IDX_DEC;
        end
      end
      tle_pkg::S_FIN: begin
        cmd_o.emit_ch = tle_pkg::CH_LF;
        if (stat_i.can_emit) begin
          cmd_o.emit = 1'b1;
          cmd_o.op   = tle_pkg::OP_TAIL_ZERO;
        end
      end
      tle_pkg::S_E_MARK: begin
        cmd_o.emit      = stat_i.can_emit;
        cmd_o.emit_kind = tle_pkg::KIND_MARK;
      end
      tle_pkg::S_FIN_END: cmd_o.op = tle_pkg::OP_FIN_END;
      tle_pkg::S_DONE:    cmd_o.flush = stat_i.hold_v && stat_i.flush_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tle_pkg::S_IDLE;
      path_q  <= tle_pkg::P_BS;
    end else begin
      state_q <= state_d;
      path_q  <= path_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/terminal_line_editor_with_history_core.sv */
`default_nettype none
// Line editor for a serial terminal with command history. One received byte
// is taken per request; the block answers with the echo bytes for the terminal
// and, on a line end, the finished line bytes and a length marker, the final
// result of each request flagged by last. Bytes are handled one at a time: a
// request's work goes through the single-port line store with a registered
// read, so every byte moved inside the line or echoed from it is first read
// and then written or echoed. A stalled output adds its wait. A new request is
// taken once the previous one's results are all handed over to the output
// register. LINE_SIZE is the slot size in bytes (lines hold up to LINE_SIZE-1),
// HISTORY_SLOTS the number of history slots.
module terminal_line_editor_with_history_core #(
  parameter int LINE_SIZE     = 16,
  parameter int HISTORY_SLOTS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_char_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       out_char_o,
  output logic [3:0]       line_length_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tle_pkg::dp_cmd_t  cmd;
  tle_pkg::dp_stat_t stat;

  // Sequencer
  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Line store, editing state, result staging and registers
  tle_dp #(
    .LINE_SIZE     (LINE_SIZE),
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_char_i     (rx_char_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_char_o    (out_char_o),
    .line_length_o (line_length_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

endmodule
`default_nettype wire

/* tb/terminal_line_editor_with_history_core_tb.sv */
`timescale 1ns / 1ps
module terminal_line_editor_with_history_core_tb;

  localparam int LSZ      = 16;
  localparam int SLOTS    = 4;
  localparam int N_DIR    = 25;
  localparam int WD_LIMIT = 6000;
  localparam int SETTLE   = 150;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] len;
    logic       fin;
  } echo_t;

  typedef struct {
    logic [7:0] rx;
    bit         chk;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] len;
  } key_row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, out_ready_i;
  logic [7:0]  rx_char_i;
  logic        in_ready_o, out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  out_char_o;
  logic [3:0]  line_length_o;
  logic        last_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  terminal_line_editor_with_history_core dut (.*);

  // Editor state mirror
  logic [7:0] lbuf [SLOTS][LSZ];
  logic [4:0] slen [SLOTS];
  int unsigned wslot, hslot, bslot, cur, esc_ph;
  bit          cr_wait;
  logic [1:0]  end_mode_q;
  logic [7:0]  bs_code_q;

  echo_t       echo_q[$];
  logic [7:0]  key_q[$];
  int          errors, n_acc, n_res, n_lines, stall_req, idle_cnt;
  bit          calm;

  // Keystroke table: typed values only where obvious
  key_row_t key_tab [N_DIR] = '{
    '{tle_pkg::CH_CR,    1, tle_pkg::KIND_MARK, tle_pkg::CH_NUL, 4'd0},
    '{8'h61,             1, tle_pkg::KIND_ECHO, 8'h61,  4'd0},
    '{tle_pkg::CH_SPACE, 1, tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 4'd0},
    '{tle_pkg::CH_TILDE, 1, tle_pkg::KIND_ECHO, tle_pkg::CH_TILDE, 4'd0},
    '{tle_pkg::CH_ESC,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_BRACK, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_LEFT,  1, tle_pkg::KIND_ECHO, tle_pkg::CH_BS,  4'd0},
    '{tle_pkg::CH_BS,    1, tle_pkg::KIND_ECHO, tle_pkg::CH_BS,  4'd0},
    '{tle_pkg::CH_DEL,   1, tle_pkg::KIND_ECHO, tle_pkg::CH_BS,  4'd0},
    '{tle_pkg::CH_ESC,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_BRACK, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_RIGHT, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_ESC,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_BRACK, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_THREE, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_TILDE, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{8'h80,             0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{8'hFF,             0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_NUL,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_ESC,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{8'h78,             0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_ESC,   0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_BRACK, 0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_UP,    0, tle_pkg::KIND_ECHO, tle_pkg::CH_NUL, 4'd0},
    '{tle_pkg::CH_CR,    1, tle_pkg::KIND_MARK, tle_pkg::CH_NUL, 4'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- echo predictor ----------------
  task automatic put(logic [1:0] k, logic [7:0] c, logic [3:0] l);
    echo_q.push_back('{k, c, l, 1'b0});
  endtask

  task automatic put_tail(int unsigned from);
    for (int unsigned i = from; i < slen[wslot]; i++) begin
      put(tle_pkg::KIND_ECHO, lbuf[wslot][i], 4'd0);
    end
  endtask

  task automatic put_rep(logic [7:0] c, int unsigned n);
    repeat (n) put(tle_pkg::KIND_ECHO, c, 4'd0);
  endtask

  task automatic drop_at(int unsigned pos);
    int unsigned n;
    n = slen[wslot];
    for (int unsigned i = pos; i + 1 < n; i++) lbuf[wslot][i] = lbuf[wslot][i+1];
    slen[wslot] = 5'(n - 1);
  endtask

  task automatic del_key();
    int unsigned b;
    if (cur >= slen[wslot]) return;
    b = slen[wslot] - cur;
    drop_at(cur);
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 4'd0);
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 4'd0);
    put_tail(cur);
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 4'd0);
    put_rep(tle_pkg::CH_BS, b);
  endtask

  task automatic bs_key();
    int unsigned b;
    if (cur == 0) return;
    cur--;
    b = slen[wslot] - cur;
    drop_at(cur);
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 4'd0);
    put_tail(cur);
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 4'd0);
    put_rep(tle_pkg::CH_BS, b);
  endtask

  task automatic ins_key(logic [7:0] c);
    int unsigned n;
    n = slen[wslot];
    if (n >= LSZ - 1) return;
    for (int unsigned i = n; i > cur; i--) lbuf[wslot][i] = lbuf[wslot][i-1];
    lbuf[wslot][cur] = c;
    n++;
    slen[wslot] = 5'(n);
    put_tail(cur);
    cur++;
    put_rep(tle_pkg::CH_BS, n - cur);
  endtask

  task automatic recall_line(bit older);
    int unsigned prev, n;
    put_rep(tle_pkg::CH_BS, cur);
    prev = slen[wslot];
    if (older) bslot = (bslot == 0) ? hslot : bslot - 1;
    else       bslot = (bslot >= hslot) ? 0 : bslot + 1;
    n = 0;
    if (bslot != wslot && bslot < SLOTS) begin
      n = slen[bslot];
      if (n > LSZ - 1) n = LSZ - 1;
      for (int unsigned i = 0; i < n; i++) lbuf[wslot][i] = lbuf[bslot][i];
    end
    slen[wslot] = 5'(n);
    put_tail(0);
    cur = n;
    if (prev > n) begin
      put_rep(tle_pkg::CH_SPACE, prev - n);
      put_rep(tle_pkg::CH_BS, prev - n);
    end
  endtask

  task automatic end_line();
    int unsigned n;
    n = slen[wslot];
    put(tle_pkg::KIND_ECHO, tle_pkg::CH_LF, 4'd0);
    for (int unsigned i = 0; i < n; i++) put(tle_pkg::KIND_LINE, lbuf[wslot][i], 4'd0);
    put(tle_pkg::KIND_MARK, tle_pkg::CH_NUL, 4'(n));
    n_lines++;
    if (n != 0) begin
      if (hslot < SLOTS - 1) hslot++;
      wslot++;
      if (wslot > hslot) wslot = 0;
    end
    slen[wslot] = '0;
    bslot = wslot;
    cur = 0;
    esc_ph = tle_pkg::PH_NONE;
    cr_wait = 0;
  endtask

  task automatic edit_key(logic [7:0] c);
    int unsigned ph;
    ph = esc_ph;
    esc_ph = tle_pkg::PH_NONE;
    case (ph)
      tle_pkg::PH_NONE: begin
        if (c == tle_pkg::CH_ESC) esc_ph = tle_pkg::PH_ESC;
        else if (c == bs_code_q) bs_key();
        else if (c == tle_pkg::CH_DEL) del_key();
        else if (c >= tle_pkg::CH_SPACE && c <= tle_pkg::CH_TILDE) ins_key(c);
      end
      tle_pkg::PH_ESC: if (c == tle_pkg::CH_BRACK) esc_ph = tle_pkg::PH_CSI;
      tle_pkg::PH_CSI: begin
        if (c == tle_pkg::CH_UP) recall_line(1);
        else if (c == tle_pkg::CH_DOWN) recall_line(0);
        else if (c == tle_pkg::CH_LEFT) begin
          if (cur != 0) begin
            put(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 4'd0);
            cur--;
          end
        end else if (c == tle_pkg::CH_RIGHT) begin
          if (cur < slen[wslot]) begin
            put(tle_pkg::KIND_ECHO, lbuf[wslot][cur], 4'd0);
            cur++;
          end
        end else if (c == tle_pkg::CH_THREE) esc_ph = tle_pkg::PH_THREE;
      end
      default: if (c == tle_pkg::CH_TILDE) del_key();
    endcase
  endtask

  task automatic predict_key(logic [7:0] c);
    logic [1:0] m;
    int         n0;
    n0 = echo_q.size();
    m = (end_mode_q == 2'd3) ? tle_pkg::MODE_CRLF : end_mode_q;
    if (m == tle_pkg::MODE_CRLF && cr_wait) begin
      cr_wait = 0;
      if (c == tle_pkg::CH_LF) end_line();
    end else if (m != tle_pkg::MODE_LF && c == tle_pkg::CH_CR) begin
      if (m == tle_pkg::MODE_CR) end_line();
      else cr_wait = 1;
    end else if (m == tle_pkg::MODE_LF && c == tle_pkg::CH_LF) begin
      end_line();
    end else begin
      edit_key(c);
    end
    if (echo_q.size() > n0) echo_q[$].fin = 1'b1;
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    echo_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_res++;
        if (echo_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d char=%h len=%0d last=%0b", $time,
                   kind_o, out_char_o, line_length_o, last_o);
        end else begin
          e = echo_q.pop_front();
          if (kind_o !== e.kind || out_char_o !== e.ch || line_length_o !== e.len ||
              last_o !== e.fin) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d char=%h len=%0d last=%0b, got %0d %h %0d %0b",
                     $time, e.kind, e.ch, e.len, e.fin, kind_o, out_char_o, line_length_o,
                     last_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_key(rx_char_i);
        if (n_acc < N_DIR && key_tab[n_acc].chk) begin
          if (echo_q.size() == 0 || echo_q[$].kind !== key_tab[n_acc].kind ||
              echo_q[$].ch !== key_tab[n_acc].ch || echo_q[$].len !== key_tab[n_acc].len) begin
            errors++;
            $display("%0t: keystroke %0d expected final kind=%0d char=%h len=%0d", $time,
                     n_acc, key_tab[n_acc].kind, key_tab[n_acc].ch, key_tab[n_acc].len);
          end
        end
        n_acc++;
      end
    end
  end

  // Watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Output side stalls
  always @(posedge clk_i) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_req > 0) begin
      out_ready_i <= 1'b0;
      stall_req <= stall_req - 1;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) out_ready_i <= 1'b1;
      else if (r < 97) begin
        out_ready_i <= 1'b0;
        stall_req <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        stall_req <= $urandom_range(15, 60);
      end
    end
  end

  // ---------------- drivers ----------------
  task automatic send_key(logic [7:0] c);
    int g;
    in_valid_i <= 1'b1;
    rx_char_i  <= c;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    g = calm ? 0 : $urandom_range(0, 99);
    if (g >= 55) begin
      in_valid_i <= 1'b0;
      repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 80)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == {tle_pkg::REG_END_MODE, 2'b00}) end_mode_q = d[1:0];
    else bs_code_q = d[7:0];
    // read back
    @(posedge clk_i);
    psel <= 1'b1; paddr <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== d) begin
      errors++;
      $display("%0t: register %0d read expected %h got %h", $time, a, d, prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random keystrokes, mostly well-formed editing
  task automatic gen_keys(int n);
    int r, k;
    logic [1:0] m;
    m = (end_mode_q == 2'd3) ? tle_pkg::MODE_CRLF : end_mode_q;
    while (key_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        repeat (k) key_q.push_back(8'($urandom_range(tle_pkg::CH_SPACE, tle_pkg::CH_TILDE)));
      end else if (r < 50) begin
        key_q.push_back(tle_pkg::CH_ESC);
        key_q.push_back(tle_pkg::CH_BRACK);
        case ($urandom_range(0, 4))
          0: key_q.push_back(tle_pkg::CH_UP);
          1: key_q.push_back(tle_pkg::CH_DOWN);
          2: key_q.push_back(tle_pkg::CH_LEFT);
          3: key_q.push_back(tle_pkg::CH_RIGHT);
          default: begin
            key_q.push_back(tle_pkg::CH_THREE);
            key_q.push_back(tle_pkg::CH_TILDE);
          end
        endcase
      end else if (r < 58) key_q.push_back(bs_code_q);
      else if (r < 63) key_q.push_back(tle_pkg::CH_DEL);
      else if (r < 80) begin
        if (m == tle_pkg::MODE_LF) key_q.push_back(tle_pkg::CH_LF);
        else key_q.push_back(tle_pkg::CH_CR);
        if (m == tle_pkg::MODE_CRLF) key_q.push_back(($urandom_range(0, 4) == 0) ?
                                            8'($urandom_range(0, 255)) : tle_pkg::CH_LF);
      end else if (r < 88) begin
        key_q.push_back(tle_pkg::CH_ESC);
        if ($urandom_range(0, 1)) key_q.push_back(tle_pkg::CH_BRACK);
        key_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        key_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------- main sequence ----------------
  logic [1:0] mode_set [6] = '{tle_pkg::MODE_CR, tle_pkg::MODE_LF, tle_pkg::MODE_CRLF, 2'd3,
                               tle_pkg::MODE_CRLF, tle_pkg::MODE_CR};
  logic [7:0] bs_set   [6] = '{tle_pkg::CH_BS, tle_pkg::CH_DEL, tle_pkg::CH_ESC, 8'h78, 8'hFF,
                               tle_pkg::CH_NUL};

  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; rx_char_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_acc = 0; n_res = 0; n_lines = 0; stall_req = 0; idle_cnt = 0;
    calm = 1'b0;
    for (int s = 0; s < SLOTS; s++) slen[s] = '0;
    wslot = 0; hslot = 0; bslot = 0; cur = 0; esc_ph = tle_pkg::PH_NONE; cr_wait = 0;
    end_mode_q = tle_pkg::MODE_CR; bs_code_q = tle_pkg::CH_BS;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed keystrokes at reset settings
    for (int i = 0; i < N_DIR; i++) send_key(key_tab[i].rx);
    drain();

    // random phases over line end modes and backspace codes
    for (int p = 0; p < 6; p++) begin
      reg_write({tle_pkg::REG_END_MODE, 2'b00}, {30'd0, mode_set[p]});
      reg_write({tle_pkg::REG_BS_CODE, 2'b00}, {24'd0, bs_set[p]});
      calm = (p == 3);
      gen_keys(32);
      while (key_q.size() != 0) begin
        if (p == 1 && key_q.size() == 20) stall_req = 700;
        send_key(key_q.pop_front());
      end
      drain();
    end

    $display("Covered %0d keystrokes and %0d results over 6 register settings,", n_acc, n_res);
    $display("with %0d completed lines.", n_lines);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/tle_pkg.sv
hdl/tle_dp.sv
hdl/tle_ctrl.sv
hdl/terminal_line_editor_with_history_core.sv
tb/terminal_line_editor_with_history_core_tb.sv
